[hdl/frac_red_pkg.sv]
// Package for the fraction reducer: default width and sequencer state codes.
`default_nettype none

package frac_red_pkg;

  // Default data width of the numerator and denominator.
  localparam int DATA_WIDTH_DEF = 32;

  // Sequencer state.
  typedef logic [2:0] state_t;

  localparam state_t ST_IDLE = 3'd0;
  localparam state_t ST_CHK  = 3'd1;
  localparam state_t ST_MOD  = 3'd2;
  localparam state_t ST_DIVN = 3'd3;
  localparam state_t ST_DIVD = 3'd4;
  localparam state_t ST_DONE = 3'd5;

endpackage

`default_nettype wire

[hdl/fraction_reducer.sv]
// Fraction reducer: Euclid's remainder method over one shared bit-serial divider.
// Per item: Euclid remainder steps until the remainder is zero (one step for a zero
//   numerator), then the numerator and the denominator are each divided by the gcd.
// Throughput: one item at a time; in_ready stays low until the result item is taken.
// Every remainder and both final quotients come from one restoring divider that
//   resolves one quotient bit per cycle.
// Reset (rst, synchronous, active high) returns the sequencer to idle and drops out_valid.
`default_nettype none

module fraction_reducer #(
  parameter int DATA_WIDTH = frac_red_pkg::DATA_WIDTH_DEF
) (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          in_valid,
  output logic                         in_ready,
  input  wire signed [DATA_WIDTH-1:0]  num_in,
  input  wire signed [DATA_WIDTH-1:0]  den_in,
  output logic                         out_valid,
  input  wire                          out_ready,
  output logic signed [DATA_WIDTH-1:0] num_out,
  output logic [DATA_WIDTH-2:0]        den_out,
  output logic                         show_den
);

  import frac_red_pkg::*;

  localparam int W  = DATA_WIDTH;
  localparam int CW = $clog2(W);
  localparam logic [CW-1:0] LAST_STEP = CW'(W - 1);

  // Sequencer and operand registers.
  state_t          state;
  logic [W-1:0]    nmag;
  logic [W-1:0]    dmag;
  logic [W-1:0]    a;
  logic [W-1:0]    b;
  logic            neg;
  logic [W-1:0]    qn;

  // Shared divider registers: quotient register shifts the dividend out at the top.
  logic [W-1:0]    div_rem;
  logic [W-1:0]    div_quo;
  logic [W-1:0]    div_dvs;
  logic [CW-1:0]   div_cnt;

  // Input magnitudes and signs; a zero denominator is read as one.
  logic [W-1:0]    den_fix;
  logic            nneg_in;
  logic            dneg_in;
  logic [W-1:0]    nmag_in;
  logic [W-1:0]    dmag_in;

  always_comb begin
    den_fix = (den_in == '0) ? W'(1) : den_in;
    nneg_in = num_in[W-1];
    dneg_in = den_fix[W-1];
    nmag_in = nneg_in ? (~num_in + W'(1)) : num_in;
    dmag_in = dneg_in ? (~den_fix + W'(1)) : den_fix;
  end

  // One restoring division step.
  logic [W:0]      div_shift;
  logic            div_ge;
  logic [W-1:0]    rem_step;
  logic [W-1:0]    quo_step;
  logic            div_last;

  always_comb begin
    div_shift = {div_rem, div_quo[W-1]};
    div_ge    = (div_shift >= {1'b0, div_dvs});
    rem_step  = div_ge ? W'(div_shift - {1'b0, div_dvs}) : div_shift[W-1:0];
    quo_step  = {div_quo[W-2:0], div_ge};
    div_last  = (div_cnt == LAST_STEP);
  end

  // Final result formatting: saturate magnitudes; the sign is applied when the result is registered.
  logic [W-1:0]    qn_sat;
  logic [W-2:0]    qd_sat;

  always_comb begin
    qn_sat = qn[W-1] ? {1'b0, {(W-1){1'b1}}} : qn;
    qd_sat = quo_step[W-1] ? {(W-1){1'b1}} : quo_step[W-2:0];
  end

  assign in_ready = (state == ST_IDLE);

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (in_valid) begin
            nmag     <= nmag_in;
            dmag     <= dmag_in;
            a        <= nmag_in;
            b        <= dmag_in;
            neg      <= nneg_in ^ dneg_in;
            show_den <= (den_fix != W'(1));
            state    <= ST_CHK;
          end
        end
        ST_CHK: begin
          div_rem <= '0;
          div_cnt <= '0;
          if (b == '0) begin
            // a holds the divisor; start on the numerator.
            div_quo <= nmag;
            div_dvs <= a;
            state   <= ST_DIVN;
          end else begin
            div_quo <= a;
            div_dvs <= b;
            state   <= ST_MOD;
          end
        end
        ST_MOD: begin
          div_rem <= rem_step;
          div_quo <= quo_step;
          div_cnt <= div_cnt + CW'(1);
          if (div_last) begin
            a     <= b;
            b     <= rem_step;
            state <= ST_CHK;
          end
        end
        ST_DIVN: begin
          div_rem <= rem_step;
          div_quo <= quo_step;
          div_cnt <= div_cnt + CW'(1);
          if (div_last) begin
            qn      <= quo_step;
            div_rem <= '0;
            div_quo <= dmag;
            div_cnt <= '0;
            state   <= ST_DIVD;
          end
        end
        ST_DIVD: begin
          div_rem <= rem_step;
          div_quo <= quo_step;
          div_cnt <= div_cnt + CW'(1);
          if (div_last) begin
            num_out   <= (neg && qn_sat != '0) ? (~qn_sat + W'(1)) : qn_sat;
            den_out   <= qd_sat;
            out_valid <= 1'b1;
            state     <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_ready) begin
            out_valid <= 1'b0;
            state     <= ST_IDLE;
          end
        end
        default: begin
          out_valid <= 1'b0;
          state     <= ST_IDLE;
        end
      endcase
    end
  end

  // The block never offers a result while it is ready for a new item.
  a_ready_excl: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid))
    else $error("in_ready and out_valid high together");

  // The shared divider never runs with a zero divisor.
  a_dvs_nonzero: assert property (@(posedge clk) disable iff (rst)
    (state == ST_MOD || state == ST_DIVN || state == ST_DIVD) |-> (div_dvs != '0))
    else $error("divider running with zero divisor");

  // A result always carries a nonzero denominator.
  a_den_pos: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (den_out != '0))
    else $error("zero denominator in result");

  // An accepted item drops ready on the following cycle.
  a_busy: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("ready stayed high after acceptance");

endmodule

`default_nettype wire

[test/tb_fraction_reducer.sv]
// Self-checking testbench for the fraction reducer: directed and random fractions.
module tb_fraction_reducer;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int W = frac_red_pkg::DATA_WIDTH_DEF;
  localparam logic signed [W-1:0] MAXV = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] MINV = {1'b1, {(W-1){1'b0}}};
  localparam int RANDOM_ITEMS = 1330;
  localparam int DRAIN_CYCLES = 1600;
  localparam int DIRECTED_ITEMS = 24;

  // Directed fractions: zero numerator and denominator, unit denominators of both signs,
  // every sign combination, the extremes and a worst case for Euclid's method.
  localparam logic signed [W-1:0] DIR_NUM [DIRECTED_ITEMS] = '{
    0, 0, 0, 7, -7, 6, -6, 5, 12, -12, 12, -12,
    2147483647, 2147483647, -2147483647, 2147483647, 1, -2147483647, 2147483647,
    2147483646, 1836311903, -1134903170, 1, -100};
  localparam logic signed [W-1:0] DIR_DEN [DIRECTED_ITEMS] = '{
    1, -5, 0, 0, 0, -1, -1, 1, 18, 18, -18, -18,
    2147483647, -2147483647, 2147483647, 1, 2147483647, -1, 2,
    1073741823, 1134903170, 1836311903, -1, 100};

  typedef struct {
    logic signed [W-1:0] num;
    logic [W-2:0]        den;
    logic                show;
  } reduced_t;

  typedef enum {READY_ALWAYS, READY_COIN, READY_LONG_STALLS} stall_mode_t;

  // Holds the reduced fractions still awaited from the block, oldest first.
  class reduced_fraction_ledger;
    reduced_t    awaited[$];
    int unsigned mismatches;

    // Lowest terms by Euclid's remainder method, sign carried by the numerator.
    function reduced_t reduce_fraction(input logic [W-1:0] n, input logic [W-1:0] d);
      logic [W-1:0] draw, nmag, dmag, a, b, r, qn, qd;
      logic         nneg, dneg;
      reduced_t     res;
      draw = (d == '0) ? 1 : d;
      nneg = n[W-1];
      dneg = draw[W-1];
      nmag = nneg ? -n : n;
      dmag = dneg ? -draw : draw;
      a = nmag;
      b = dmag;
      while (b != '0) begin
        r = a % b;
        a = b;
        b = r;
      end
      qn = nmag / a;
      qd = dmag / a;
      if (qn > MAXV) qn = MAXV;
      if (qd > MAXV) qd = MAXV;
      res.num  = ((nneg != dneg) && qn != '0) ? -qn : qn;
      res.den  = qd[W-2:0];
      res.show = (draw != 1);
      return res;
    endfunction

    function void note_fraction(input logic [W-1:0] n, input logic [W-1:0] d);
      awaited.push_back(reduce_fraction(n, d));
    endfunction

    function void check_reduced(input logic signed [W-1:0] num, input logic [W-2:0] den,
                                input logic show);
      reduced_t want;
      if (awaited.size() == 0) begin
        $display("%0t: result %0d/%0d show_den %0b, expected none", $time, num, den, show);
        mismatches++;
        return;
      end
      want = awaited.pop_front();
      if (num !== want.num) begin
        $display("%0t: num_out expected %0d, actual %0d", $time, want.num, num);
        mismatches++;
      end
      if (den !== want.den) begin
        $display("%0t: den_out expected %0d, actual %0d", $time, want.den, den);
        mismatches++;
      end
      if (show !== want.show) begin
        $display("%0t: show_den expected %0b, actual %0b", $time, want.show, show);
        mismatches++;
      end
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic signed [W-1:0] num_in = '0;
  logic signed [W-1:0] den_in = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic signed [W-1:0] num_out;
  logic [W-2:0]        den_out;
  logic                show_den;

  reduced_fraction_ledger ledger;
  int unsigned            fib [47];
  stall_mode_t            ready_mode = READY_ALWAYS;
  int                     mode_left = 0;
  int                     stall_left = 0;
  logic                   ready_next;

  fraction_reducer #(.DATA_WIDTH(W)) u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .num_in    (num_in),
    .den_in    (den_in),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .num_out   (num_out),
    .den_out   (den_out),
    .show_den  (show_den)
  );

  always #10 clk = ~clk;

  // Results are checked at the rising edge at which they are taken.
  always @(posedge clk) begin
    if (!rst && out_valid === 1'b1 && out_ready) begin
      ledger.check_reduced(num_out, den_out, show_den);
    end
  end

  // The receiver switches now and then between always ready, coin tosses and long stalls.
  always @(negedge clk) begin
    if (mode_left == 0) begin
      ready_mode = stall_mode_t'($urandom_range(0, 2));
      mode_left  = $urandom_range(500, 3000);
    end else begin
      mode_left--;
    end
    if (stall_left != 0) begin
      stall_left--;
      ready_next = 1'b0;
    end else begin
      case (ready_mode)
        READY_ALWAYS: ready_next = 1'b1;
        READY_COIN:   ready_next = $urandom_range(0, 1);
        default: begin
          if ($urandom_range(0, 15) == 0) begin
            stall_left = $urandom_range(1, 60);
            ready_next = 1'b0;
          end else begin
            ready_next = 1'b1;
          end
        end
      endcase
    end
    out_ready <= ready_next;
  end

  function automatic logic signed [W-1:0] any_sign(input logic signed [W-1:0] v);
    return $urandom_range(0, 1) ? -v : v;
  endfunction

  // Draws one fraction; some carry a common factor or are hard for Euclid's method.
  task automatic pick_fraction(output logic signed [W-1:0] n, output logic signed [W-1:0] d);
    int unsigned f, lim, k;
    case ($urandom_range(0, 9))
      0, 1, 2: begin
        n = $urandom;
        d = $urandom;
      end
      3, 4: begin
        f   = $urandom_range(1, 5000);
        lim = $urandom_range(1, MAXV / f);
        n   = any_sign($urandom_range(0, lim) * f);
        d   = any_sign($urandom_range(0, lim) * f);
      end
      5, 6: begin
        n = any_sign($urandom_range(0, 40));
        d = any_sign($urandom_range(0, 40));
      end
      7: begin
        k = $urandom_range(2, 46);
        f = $urandom_range(1, MAXV / fib[k]);
        if ($urandom_range(0, 1)) begin
          n = any_sign(fib[k] * f);
          d = any_sign(fib[k-1] * f);
        end else begin
          n = any_sign(fib[k-1] * f);
          d = any_sign(fib[k] * f);
        end
      end
      8: begin
        n = $urandom;
        case ($urandom_range(0, 3))
          0: d = 0;
          1: d = 1;
          2: d = -1;
          default: begin
            d = $urandom;
            n = 0;
          end
        endcase
      end
      default: begin
        n = $urandom & ({W{1'b1}} << $urandom_range(1, 30));
        d = $urandom & ({W{1'b1}} << $urandom_range(1, 30));
      end
    endcase
    // The most negative value is outside the input range.
    if (n == MINV) n = MAXV;
    if (d == MINV) d = MAXV;
  endtask

  // Presents one fraction and holds it until the block takes it.
  task automatic send_fraction(input logic signed [W-1:0] n, input logic signed [W-1:0] d);
    @(negedge clk);
    in_valid <= 1'b1;
    num_in   <= n;
    den_in   <= d;
    do @(posedge clk); while (in_ready !== 1'b1);
    ledger.note_fraction(n, d);
  endtask

  // Leaves the input idle for a number of cycles, with noise on the payload.
  task automatic rest_sender(input int cycles);
    if (cycles == 0) return;
    @(negedge clk);
    in_valid <= 1'b0;
    num_in   <= $urandom;
    den_in   <= $urandom;
    repeat (cycles - 1) @(negedge clk);
  endtask

  // Stimulus: reset, directed fractions back to back, then random bursts.
  initial begin
    int                  burst_left;
    int                  gap;
    logic signed [W-1:0] n, d;
    ledger = new();
    fib[0] = 0;
    fib[1] = 1;
    for (int i = 2; i < 47; i++) fib[i] = fib[i-1] + fib[i-2];
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    for (int i = 0; i < DIRECTED_ITEMS; i++) send_fraction(DIR_NUM[i], DIR_DEN[i]);
    burst_left = 0;
    repeat (RANDOM_ITEMS) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 8);
        gap = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 700) : $urandom_range(0, 12);
        rest_sender(gap);
      end
      pick_fraction(n, d);
      send_fraction(n, d);
      burst_left--;
    end
    @(negedge clk);
    in_valid <= 1'b0;
    while (ledger.awaited.size() != 0) @(posedge clk);
    // Give any stray result time to appear.
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (ledger.mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Timeout well beyond the slowest correct run.
  initial begin
    #250_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
